FILE: rtl/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
// Depends on nothing; used by spq_cell and sorted_priority_queue.
package spq_pkg;

    // Operation codes carried in the mode field of an input word.
    typedef enum logic [1:0] {
        MODE_PUSH = 2'd0,
        MODE_POP  = 2'd1,
        MODE_PEEK = 2'd2
    } t_mode;

    // Control broadcast from the top level to every cell of the chain.
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

endpackage

FILE: rtl/spq_cell.sv
// One slot of the sorted chain: holds a (priority, data) pair and moves it
// towards its neighbours on insert and removal. Depends on spq_pkg.
module spq_cell #(
    parameter int PRIO_BITS = 16,
    parameter int DATA_BITS = 32
) (
    input  logic                  i_clk,
    input  spq_pkg::t_cell_ctl    i_ctl,
    input  logic                  i_occupied,
    input  logic [PRIO_BITS-1:0]  i_new_prio,
    input  logic [DATA_BITS-1:0]  i_new_data,
    input  logic                  i_left_move,
    input  logic [PRIO_BITS-1:0]  i_left_prio,
    input  logic [DATA_BITS-1:0]  i_left_data,
    input  logic [PRIO_BITS-1:0]  i_right_prio,
    input  logic [DATA_BITS-1:0]  i_right_data,
    output logic                  o_move,
    output logic [PRIO_BITS-1:0]  o_prio,
    output logic [DATA_BITS-1:0]  o_data
);

    logic [PRIO_BITS-1:0] r_prio;
    logic [DATA_BITS-1:0] r_data;

    // The new entry goes in at or before this slot when the slot is free or
    // holds a strictly greater priority; equal priorities stay ahead.
    assign o_move = !i_occupied || (r_prio > i_new_prio);
    assign o_prio = r_prio;
    assign o_data = r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push && o_move) begin
            if (i_left_move) begin
                r_prio <= i_left_prio;
                r_data <= i_left_data;
            end else begin
                r_prio <= i_new_prio;
                r_data <= i_new_data;
            end
        end else if (i_ctl.pop) begin
            r_prio <= i_right_prio;
            r_data <= i_right_data;
        end
    end

endmodule

FILE: rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: a chain of spq_cell slots with
// a fill count and a registered result word. Depends on spq_pkg, spq_cell.
//
// Usage. Each input word carries an operation (push, pop head, peek head),
// a priority and a data word. Every accepted word yields exactly one result
// word: a success flag, the head entry for pop and peek (zero otherwise),
// the entry count after the operation and an empty flag. Entries leave in
// ascending priority order; equal priorities leave first in, first out.
// A push into a full queue and a pop or peek on an empty queue give ok low
// and leave the queue unchanged.
// The result word is valid in the cycle after the input word is accepted.
// Throughput is one word per cycle while the receiver does not stall, set
// by the broadcast compare and shift in the cell chain; every slot
// compares against the incoming priority at once.
// Reset clears the fill count and the output valid; slot contents are not
// cleared and are only read once written. While a result word waits under
// stall from the receiver, the input channel is stalled as well, so no
// word is lost or reordered.
module sorted_priority_queue #(
    parameter int CAPACITY  = 16,
    parameter int PRIO_BITS = 16,
    parameter int DATA_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_mode,
    input  logic [15:0]        i_in_prio,
    input  logic signed [31:0] i_in_data,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_ok,
    output logic [15:0]        o_out_prio,
    output logic signed [31:0] o_out_data,
    output logic [4:0]         o_entry_count,
    output logic               o_is_empty
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                 w_accept;
    logic                 w_is_push;
    logic                 w_is_pop;
    logic                 w_is_peek;
    logic                 w_full;
    logic                 w_empty;
    spq_pkg::t_cell_ctl   w_ctl;
    logic [PRIO_BITS-1:0] w_new_prio;
    logic [DATA_BITS-1:0] w_new_data;
    logic [15:0]          w_head_prio;
    logic [31:0]          w_head_data;

    logic [PRIO_BITS-1:0] w_prio [CAPACITY];
    logic [DATA_BITS-1:0] w_data [CAPACITY];
    logic [CAPACITY-1:0]  w_move;
    logic [CAPACITY-1:0]  w_occ;

    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_valid;
    logic             r_ok, n_ok;
    logic [15:0]      r_prio, n_prio;
    logic [31:0]      r_data, n_data;
    logic [CNT_W-1:0] r_res_count;
    logic             r_empty;

    // The input side waits only while a finished result is held back.
    assign o_stall  = r_out_valid && i_stall;
    assign w_accept = i_valid && !o_stall;

    assign w_is_push = (i_mode == spq_pkg::MODE_PUSH);
    assign w_is_pop  = (i_mode == spq_pkg::MODE_POP);
    assign w_is_peek = (i_mode == spq_pkg::MODE_PEEK);
    assign w_full    = (r_count == CNT_W'(CAPACITY));
    assign w_empty   = (r_count == '0);

    assign w_ctl.push = w_accept && w_is_push && !w_full;
    assign w_ctl.pop  = w_accept && w_is_pop && !w_empty;

    // Fit the incoming fields to the stored widths; both are zero-extended
    // when the slots are wider than the ports.
    generate
        if (PRIO_BITS >= 16) begin : g_prio_wide
            assign w_new_prio  = PRIO_BITS'(i_in_prio);
            assign w_head_prio = w_prio[0][15:0];
        end else begin : g_prio_narrow
            assign w_new_prio  = i_in_prio[PRIO_BITS-1:0];
            assign w_head_prio = 16'(w_prio[0]);
        end
        if (DATA_BITS >= 32) begin : g_data_wide
            assign w_new_data  = DATA_BITS'(unsigned'(i_in_data));
            assign w_head_data = w_data[0][31:0];
        end else begin : g_data_narrow
            assign w_new_data  = i_in_data[DATA_BITS-1:0];
            assign w_head_data = {{(32 - DATA_BITS){w_data[0][DATA_BITS-1]}}, w_data[0]};
        end
    endgenerate

    // The chain itself. Slot 0 is the head; a push shifts the tail of the
    // chain one place right, a pop shifts everything one place left.
    generate
        for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
            logic                 w_lm;
            logic [PRIO_BITS-1:0] w_lp;
            logic [DATA_BITS-1:0] w_ld;
            logic [PRIO_BITS-1:0] w_rp;
            logic [DATA_BITS-1:0] w_rd;

            assign w_occ[g] = (r_count > CNT_W'(g));

            if (g == 0) begin : g_left_end
                assign w_lm = 1'b0;
                assign w_lp = w_new_prio;
                assign w_ld = w_new_data;
            end else begin : g_left_link
                assign w_lm = w_move[g-1];
                assign w_lp = w_prio[g-1];
                assign w_ld = w_data[g-1];
            end

            if (g == CAPACITY - 1) begin : g_right_end
                assign w_rp = w_prio[g];
                assign w_rd = w_data[g];
            end else begin : g_right_link
                assign w_rp = w_prio[g+1];
                assign w_rd = w_data[g+1];
            end

            spq_cell #(
                .PRIO_BITS (PRIO_BITS),
                .DATA_BITS (DATA_BITS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_occupied   (w_occ[g]),
                .i_new_prio   (w_new_prio),
                .i_new_data   (w_new_data),
                .i_left_move  (w_lm),
                .i_left_prio  (w_lp),
                .i_left_data  (w_ld),
                .i_right_prio (w_rp),
                .i_right_data (w_rd),
                .o_move       (w_move[g]),
                .o_prio       (w_prio[g]),
                .o_data       (w_data[g])
            );
        end
    endgenerate

    // Result of the accepted word and the count it leaves behind.
    always_comb begin
        n_count = r_count;
        n_ok    = 1'b0;
        n_prio  = '0;
        n_data  = '0;
        if (w_ctl.push) begin
            n_count = r_count + CNT_W'(1);
            n_ok    = 1'b1;
        end
        if ((w_is_pop || w_is_peek) && !w_empty) begin
            n_ok   = 1'b1;
            n_prio = w_head_prio;
            n_data = w_head_data;
        end
        if (w_ctl.pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ok        <= n_ok;
            r_prio      <= n_prio;
            r_data      <= n_data;
            r_res_count <= n_count;
            r_empty     <= (n_count == '0);
        end
    end

    assign o_valid    = r_out_valid;
    assign o_ok       = r_ok;
    assign o_out_prio = r_prio;
    assign o_out_data = signed'(r_data);
    assign o_is_empty = r_empty;

    generate
        if (CNT_W >= 5) begin : g_cnt_cut
            assign o_entry_count = r_res_count[4:0];
        end else begin : g_cnt_ext
            assign o_entry_count = 5'(r_res_count);
        end
    endgenerate

    // The fill count never passes the number of slots.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("fill count beyond capacity");

    // The two front slots stay in service order.
    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |-> (w_prio[0] <= w_prio[1]))
        else $error("head slots out of order");

    // A pop on a non-empty queue removes exactly one entry.
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_is_pop && !w_empty) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("pop did not remove one entry");

    // A peek leaves the count as it stands.
    a_peek_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_is_peek) |=> (r_count == $past(r_count)))
        else $error("peek changed the count");

    // A held result reports empty exactly when its count is zero.
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_empty == (r_res_count == '0)))
        else $error("empty flag disagrees with count");

endmodule
